[src/exptok_pkg.sv]
// ---------------------------------------------------------------------------
// exptok_pkg: shared types and constants of the expression tokeniser
// Token kinds, error kinds, lexer modes and the token record.
// ---------------------------------------------------------------------------
package exptok_pkg;

  localparam int unsigned KindW = 5;
  localparam int unsigned ValW  = 31;
  localparam logic [ValW-1:0] ValMax = {ValW{1'b1}};

  typedef enum logic [KindW-1:0] {
    K_INT = 5'd0, K_FLOAT = 5'd1, K_ID = 5'd2, K_ADD = 5'd3, K_SUB = 5'd4,
    K_NOT = 5'd5, K_MUL = 5'd6, K_DIV = 5'd7, K_LPAR = 5'd8, K_RPAR = 5'd9,
    K_ASSIGN = 5'd10, K_EQUAL = 5'd11, K_LESS = 5'd12, K_LESS_EQ = 5'd13,
    K_GREATER = 5'd14, K_GREATER_EQ = 5'd15, K_AND = 5'd16, K_OR = 5'd17,
    K_ERROR = 5'd18, K_END = 5'd19
  } kind_t;

  typedef enum logic [1:0] {
    E_NONE = 2'd0, E_ILLEGAL = 2'd1, E_AMP = 2'd2, E_BAR = 2'd3
  } err_t;

  typedef enum logic [7:0] {
    M_IDLE = 8'b0000_0001, M_NUM = 8'b0000_0010, M_ID = 8'b0000_0100,
    M_EQ   = 8'b0000_1000, M_LT  = 8'b0001_0000, M_GT = 8'b0010_0000,
    M_AMP  = 8'b0100_0000, M_BAR = 8'b1000_0000
  } mode_t;

  // One result as it leaves the block (positions in their low 16 bits)
  typedef struct packed {
    kind_t          kind;
    err_t           err;
    logic [7:0]     ch;
    logic [ValW-1:0] val;
    logic [15:0]    bi;
    logic [15:0]    fi;
    logic [15:0]    bl;
    logic [15:0]    bc;
    logic [15:0]    fl;
    logic [15:0]    fc;
    logic           last;
  } tok_t;

  // Bundle of up to three results caused by one byte
  typedef struct packed {
    logic [1:0] count;   // number of results, 1..3
    tok_t       t0;
    tok_t       t1;
    tok_t       t2;
  } bundle_t;

  function automatic logic is_num(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return c == "_" || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return c == " " || c == 8'h09 || c == 8'h0d || c == 8'h0a;
  endfunction

endpackage

[src/exptok_if.sv]
// ---------------------------------------------------------------------------
// exptok_in_if / exptok_out_if: valid-ready channels of the tokeniser
// Input carries text bytes, output carries token records.
// ---------------------------------------------------------------------------
interface exptok_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;
  modport source (output valid, text_byte, end_of_text, input ready);
  modport sink (input valid, text_byte, end_of_text, output ready);
endinterface

interface exptok_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  token_kind;
  logic [1:0]  error_kind;
  logic [7:0]  offending_char;
  logic [30:0] integer_value;
  logic [15:0] begin_index;
  logic [15:0] finish_index;
  logic [15:0] begin_line;
  logic [15:0] begin_column;
  logic [15:0] finish_line;
  logic [15:0] finish_column;
  logic        run_last;
  modport source (output valid, token_kind, error_kind, offending_char, integer_value,
                  begin_index, finish_index, begin_line, begin_column, finish_line,
                  finish_column, run_last, input ready);
  modport sink (input valid, token_kind, error_kind, offending_char, integer_value,
                begin_index, finish_index, begin_line, begin_column, finish_line,
                finish_column, run_last, output ready);
endinterface

[src/exptok_front.sv]
// ---------------------------------------------------------------------------
// exptok_front: lexer front end
// Takes one byte per beat, updates lexer state and hands a bundle of up to
// three token records to the queue.
// ---------------------------------------------------------------------------
module exptok_front #(
  parameter int unsigned POS_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_byte,
  input  logic                 in_last,
  output logic                 push,
  output exptok_pkg::bundle_t  push_data,
  input  logic                 q_full
);
  import exptok_pkg::*;

  typedef logic [POS_BITS-1:0] pos_t;

  mode_t           lex_mode;
  pos_t            cur_index, cur_line, cur_column;
  pos_t            tok_start_index, tok_start_line, tok_start_column;
  logic [ValW-1:0] number_accum;
  logic            seen_dot, halted;

  mode_t           lex_mode_next;
  pos_t            ci_next, cl_next, cc_next, si_next, sl_next, sc_next;
  logic [ValW-1:0] acc_next;
  logic            dot_next, halt_next;
  bundle_t         bnd;
  logic            fire;

  assign in_ready = !q_full;
  assign fire     = in_valid && in_ready;

  // Decode one byte against the current mode
  always_comb begin
    logic [7:0]  c;
    logic        finish, fresh, adv, rem;
    pos_t        ni, nl, nc;
    logic [35:0] prod;
    logic [1:0]  n;
    tok_t        r [3];
    tok_t        tk;
    kind_t       okind;
    c = in_byte;
    finish = in_last || c == 8'd0;
    lex_mode_next = lex_mode;
    acc_next = number_accum;
    dot_next = seen_dot;
    halt_next = halted;
    si_next = tok_start_index;
    sl_next = tok_start_line;
    sc_next = tok_start_column;
    fresh = 1'b0;
    adv = 1'b0;
    rem = 1'b0;
    n = 2'd0;
    okind = K_ADD;
    prod = '0;
    for (int k = 0; k < 3; k++) r[k] = '0;
    tk = '0;
    // position after this byte
    ni = cur_index + pos_t'(1);
    nl = (c == 8'h0a) ? cur_line + pos_t'(1) : cur_line;
    nc = (c == 8'h0a) ? '0 : cur_column + pos_t'(1);
    if (halted) begin
      adv = c != 8'd0;
    end else if (c != 8'd0) begin
      // continue pending token
      unique case (lex_mode)
        M_NUM: begin
          if (is_num(c)) begin
            adv = 1'b1;
            if (!seen_dot) begin
              prod = {5'd0, number_accum} * 36'd10 + {28'd0, c - 8'h30};
              acc_next = (prod > {5'd0, ValMax}) ? ValMax : prod[ValW-1:0];
            end
          end else if (c == "." && !seen_dot) begin
            adv = 1'b1;
            dot_next = 1'b1;
          end else begin
            tk = '0;
            tk.kind = seen_dot ? K_FLOAT : K_INT;
            tk.val = seen_dot ? '0 : number_accum;
            tk.bi = 16'(tok_start_index); tk.bl = 16'(tok_start_line);
            tk.bc = 16'(tok_start_column);
            tk.fi = 16'(cur_index); tk.fl = 16'(cur_line); tk.fc = 16'(cur_column);
            r[0] = tk; n = 2'd1; fresh = 1'b1;
          end
        end
        M_ID: begin
          if (is_alpha(c)) adv = 1'b1;
          else begin
            tk = '0; tk.kind = K_ID;
            tk.bi = 16'(tok_start_index); tk.bl = 16'(tok_start_line);
            tk.bc = 16'(tok_start_column);
            tk.fi = 16'(cur_index); tk.fl = 16'(cur_line); tk.fc = 16'(cur_column);
            r[0] = tk; n = 2'd1; fresh = 1'b1;
          end
        end
        M_EQ, M_LT, M_GT: begin
          tk = '0;
          tk.kind = (lex_mode == M_EQ) ? K_ASSIGN : (lex_mode == M_LT) ? K_LESS : K_GREATER;
          tk.bi = 16'(tok_start_index); tk.bl = 16'(tok_start_line);
          tk.bc = 16'(tok_start_column);
          if (c == "=") begin
            tk.kind = kind_t'(tk.kind + 5'd1);
            tk.fi = 16'(ni); tk.fl = 16'(nl); tk.fc = 16'(nc);
            adv = 1'b1;
            lex_mode_next = M_IDLE;
          end else begin
            tk.fi = 16'(cur_index); tk.fl = 16'(cur_line); tk.fc = 16'(cur_column);
            fresh = 1'b1;
          end
          r[0] = tk; n = 2'd1;
        end
        M_AMP, M_BAR: begin
          tk = '0;
          tk.fi = 16'(ni); tk.fl = 16'(nl); tk.fc = 16'(nc);
          if (c == ((lex_mode == M_AMP) ? "&" : "|")) begin
            tk.kind = (lex_mode == M_AMP) ? K_AND : K_OR;
            tk.bi = 16'(tok_start_index); tk.bl = 16'(tok_start_line);
            tk.bc = 16'(tok_start_column);
          end else begin
            tk.kind = K_ERROR;
            tk.err = (lex_mode == M_AMP) ? E_AMP : E_BAR;
            tk.ch = c;
            tk.bi = 16'(cur_index); tk.bl = 16'(cur_line); tk.bc = 16'(cur_column);
          end
          r[0] = tk; n = 2'd1; adv = 1'b1;
          lex_mode_next = M_IDLE;
        end
        default: fresh = 1'b1;
      endcase
      // lex the byte from scratch
      if (fresh) begin
        lex_mode_next = M_IDLE;
        adv = 1'b1;
        if (!is_blank(c)) begin
          si_next = cur_index; sl_next = cur_line; sc_next = cur_column;
          tk = '0;
          tk.bi = 16'(cur_index); tk.bl = 16'(cur_line); tk.bc = 16'(cur_column);
          tk.fi = 16'(ni); tk.fl = 16'(nl); tk.fc = 16'(nc);
          rem = 1'b0;
          if (is_num(c)) begin
            lex_mode_next = M_NUM;
            acc_next = ValW'(c - 8'h30);
            dot_next = 1'b0;
          end else if (is_alpha(c)) begin
            lex_mode_next = M_ID;
          end else begin
            rem = 1'b1;
            unique case (c)
              "=": begin lex_mode_next = M_EQ; rem = 1'b0; end
              "<": begin lex_mode_next = M_LT; rem = 1'b0; end
              ">": begin lex_mode_next = M_GT; rem = 1'b0; end
              "&": begin lex_mode_next = M_AMP; rem = 1'b0; end
              "|": begin lex_mode_next = M_BAR; rem = 1'b0; end
              "+": okind = K_ADD;
              "-": okind = K_SUB;
              "!": okind = K_NOT;
              "*": okind = K_MUL;
              "/": okind = K_DIV;
              "(": okind = K_LPAR;
              ")": okind = K_RPAR;
              default: begin
                okind = K_ERROR;
                tk.err = E_ILLEGAL;
                tk.ch = c;
                halt_next = 1'b1;
              end
            endcase
            tk.kind = okind;
          end
          if (rem) begin
            r[n] = tk; n = n + 2'd1;
          end
        end
      end
    end
    if (adv) begin
      ci_next = ni; cl_next = nl; cc_next = nc;
    end else begin
      ci_next = cur_index; cl_next = cur_line; cc_next = cur_column;
    end
    // flush and end token
    if (finish) begin
      if (!halt_next) begin
        tk = '0;
        tk.bi = 16'(si_next); tk.bl = 16'(sl_next); tk.bc = 16'(sc_next);
        tk.fi = 16'(ci_next); tk.fl = 16'(cl_next); tk.fc = 16'(cc_next);
        rem = 1'b1;
        unique case (lex_mode_next)
          M_NUM: begin
            tk.kind = dot_next ? K_FLOAT : K_INT;
            tk.val = dot_next ? '0 : acc_next;
          end
          M_ID: tk.kind = K_ID;
          M_EQ: tk.kind = K_ASSIGN;
          M_LT: tk.kind = K_LESS;
          M_GT: tk.kind = K_GREATER;
          M_AMP, M_BAR: begin
            tk.kind = K_ERROR;
            tk.err = (lex_mode_next == M_AMP) ? E_AMP : E_BAR;
            tk.bi = 16'(ci_next); tk.bl = 16'(cl_next); tk.bc = 16'(cc_next);
          end
          default: rem = 1'b0;
        endcase
        if (rem) begin
          r[n] = tk; n = n + 2'd1;
        end
      end
      tk = '0;
      tk.kind = K_END;
      tk.bi = 16'(ci_next); tk.bl = 16'(cl_next); tk.bc = 16'(cc_next);
      tk.fi = 16'(ci_next); tk.fl = 16'(cl_next); tk.fc = 16'(cc_next);
      r[n] = tk; n = n + 2'd1;
    end
    bnd = '0;
    bnd.count = n;
    if (n != 2'd0) r[n - 2'd1].last = 1'b1;
    bnd.t0 = r[0];
    bnd.t1 = r[1];
    bnd.t2 = r[2];
  end

  assign push      = fire && bnd.count != 2'd0;
  assign push_data = bnd;

  // Commit lexer state on each accepted beat; an end-of-text or NUL beat clears it
  always_ff @(posedge clk) begin
    if (rst) begin
      lex_mode <= M_IDLE;
      cur_index <= '0; cur_line <= '0; cur_column <= '0;
      tok_start_index <= '0; tok_start_line <= '0; tok_start_column <= '0;
      number_accum <= '0; seen_dot <= 1'b0; halted <= 1'b0;
    end else if (fire) begin
      if (in_last || in_byte == 8'd0) begin
        lex_mode <= M_IDLE;
        cur_index <= '0; cur_line <= '0; cur_column <= '0;
        tok_start_index <= '0; tok_start_line <= '0; tok_start_column <= '0;
        number_accum <= '0; seen_dot <= 1'b0; halted <= 1'b0;
      end else begin
        lex_mode <= lex_mode_next;
        cur_index <= ci_next; cur_line <= cl_next; cur_column <= cc_next;
        tok_start_index <= si_next; tok_start_line <= sl_next;
        tok_start_column <= sc_next;
        number_accum <= acc_next; seen_dot <= dot_next; halted <= halt_next;
      end
    end
  end

endmodule

[src/exptok_queue.sv]
// ---------------------------------------------------------------------------
// exptok_queue: two-entry bundle queue between front and back end
// Decouples the lexer from the token serialiser.
// ---------------------------------------------------------------------------
module exptok_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  exptok_pkg::bundle_t push_data,
  output logic                full,
  output logic                not_empty,
  input  logic                pop,
  output exptok_pkg::bundle_t head
);
  import exptok_pkg::*;

  bundle_t    slot [2];
  logic       wptr, rptr;
  logic [1:0] fill;

  assign full      = fill == 2'd2;
  assign not_empty = fill != 2'd0;
  assign head      = slot[rptr];

  // Write at tail, read at head
  always_ff @(posedge clk) begin
    if (push) slot[wptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0; rptr <= 1'b0; fill <= 2'd0;
    end else begin
      if (push) wptr <= !wptr;
      if (pop) rptr <= !rptr;
      fill <= fill + 2'(push) - 2'(pop);
    end
  end

endmodule

[src/exptok_back.sv]
// ---------------------------------------------------------------------------
// exptok_back: token serialiser
// Walks a bundle one record per beat into the output register.
// ---------------------------------------------------------------------------
module exptok_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  input  exptok_pkg::bundle_t q_head,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output exptok_pkg::tok_t    out_tok
);
  import exptok_pkg::*;

  logic [1:0] sel;
  logic       load;
  tok_t       cur;

  always_comb begin
    case (sel)
      2'd0:    cur = q_head.t0;
      2'd1:    cur = q_head.t1;
      default: cur = q_head.t2;
    endcase
  end

  assign load  = q_valid && (!out_valid || out_ready);
  assign q_pop = load && (sel + 2'd1 == q_head.count);

  // Advance through the bundle, hold while output stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      sel <= 2'd0; out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        sel <= q_pop ? 2'd0 : sel + 2'd1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) out_tok <= cur;
  end

endmodule

[src/expression_tokenizer.sv]
// ---------------------------------------------------------------------------
// expression_tokenizer: streaming lexer for arithmetic expressions
// Turns text bytes into tokens with start and end positions.
// ---------------------------------------------------------------------------
//  channel   dir  beat
//  text_in   in   one text byte, end_of_text flag
//  tok_out   out  one token record, run_last flag
//
// One byte is accepted per cycle while the two-entry bundle queue has room.
// A byte gives zero to three tokens; the serialiser sends one per cycle while
// tok_out is ready, so the sustained rate is one byte per cycle when bytes
// average one token. A token passes the queue slot, then the output register.
// Synchronous reset clears lexer state, queue and output valid. Stalls on
// tok_out fill the queue, then drop text_in.ready.
module expression_tokenizer #(
  parameter int unsigned POS_BITS = 16
) (
  input logic clk,
  input logic rst,
  exptok_in_if.sink    text_in,
  exptok_out_if.source tok_out
);
  import exptok_pkg::*;

  logic    push, full, not_empty, pop;
  bundle_t push_data, head;
  tok_t    otok;

  exptok_front #(.POS_BITS(POS_BITS)) u_front (
    .clk, .rst,
    .in_valid(text_in.valid), .in_ready(text_in.ready),
    .in_byte(text_in.text_byte), .in_last(text_in.end_of_text),
    .push, .push_data, .q_full(full)
  );

  exptok_queue u_queue (
    .clk, .rst, .push, .push_data, .full, .not_empty, .pop, .head
  );

  exptok_back u_back (
    .clk, .rst, .q_valid(not_empty), .q_head(head), .q_pop(pop),
    .out_valid(tok_out.valid), .out_ready(tok_out.ready), .out_tok(otok)
  );

  assign tok_out.token_kind     = otok.kind;
  assign tok_out.error_kind     = otok.err;
  assign tok_out.offending_char = otok.ch;
  assign tok_out.integer_value  = otok.val;
  assign tok_out.begin_index    = otok.bi;
  assign tok_out.finish_index   = otok.fi;
  assign tok_out.begin_line     = otok.bl;
  assign tok_out.begin_column   = otok.bc;
  assign tok_out.finish_line    = otok.fl;
  assign tok_out.finish_column  = otok.fc;
  assign tok_out.run_last       = otok.last;

`ifndef SYNTHESIS
  // Hold a stalled token steady
  a_hold: assert property (@(posedge clk) disable iff (rst)
    tok_out.valid && !tok_out.ready |=> tok_out.valid && $stable(otok))
    else $error("token changed under stall");
  // Never push into a full queue
  a_full: assert property (@(posedge clk) disable iff (rst) !(push && full && !pop))
    else $error("queue overflow");
  // Pop only when data is queued
  a_pop: assert property (@(posedge clk) disable iff (rst) pop |-> not_empty)
    else $error("queue underflow");
`endif

endmodule
